@@ hdl/sedc_pkg.sv @@
// ----------------------------------------------------------------------------
// sedc_pkg
// Shared types and constants for the Shift_JIS / EUC-JP detector and converter.
// ----------------------------------------------------------------------------
`default_nettype none

package sedc_pkg;

  localparam int unsigned MAX_BYTES_DEF = 64;
  localparam int unsigned BYTE_W        = 8;

  // APB
  localparam int unsigned APB_AW        = 3;
  localparam int unsigned APB_DW        = 32;
  localparam logic        REG_SYS_ENC   = 1'b0;   // register index (paddr[2])

  // system_encoding register values
  localparam logic [1:0] SYS_NONE = 2'd0;
  localparam logic [1:0] SYS_EUC  = 2'd1;
  localparam logic [1:0] SYS_SJIS = 2'd2;

  // detected code / verdict
  localparam logic [1:0] CODE_UNKNOWN = 2'd0;
  localparam logic [1:0] CODE_EUC     = 2'd1;
  localparam logic [1:0] CODE_SJIS    = 2'd2;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_TO_EUC,
    MODE_TO_SJIS
  } mode_e;

  typedef enum logic [2:0] {
    S_LOAD,
    S_RD_A,
    S_GET_A,
    S_GET_B,
    S_OUT_A,
    S_OUT_B
  } state_e;

  // SJIS to EUC
  localparam logic [7:0] K_SJ_LEAD_HI = 8'he0;
  localparam logic [7:0] K_SJ_SUB_HI  = 8'he0;
  localparam logic [7:0] K_SJ_SUB_LO  = 8'h60;
  localparam logic [7:0] K_SJ_SUBO_HI = 8'he1;
  localparam logic [7:0] K_SJ_SUBO_LO = 8'h61;
  localparam logic [7:0] K_SJ_TR_SPL  = 8'h9f;
  localparam logic [7:0] K_SJ_TR_GAP  = 8'h7f;

  // EUC to SJIS (the last two are SJIS to EUC trail offsets)
  localparam logic [7:0] K_EU_LEAD_SPL = 8'hdf;
  localparam logic [7:0] K_EU_ADDO_LO  = 8'h31;
  localparam logic [7:0] K_EU_ADDO_HI  = 8'h71;
  localparam logic [7:0] K_EU_ADDE_LO  = 8'h30;
  localparam logic [7:0] K_EU_ADDE_HI  = 8'h70;
  localparam logic [7:0] K_EU_TR_SPL   = 8'he0;
  localparam logic [7:0] K_EU_SUB_LO   = 8'h61;
  localparam logic [7:0] K_EU_SUB_HI   = 8'h60;
  localparam logic [7:0] K_EU_SUB_EVEN = 8'h02;
  localparam logic [7:0] K_SJ_ADD_TR   = 8'h02;
  localparam logic [7:0] K_SJ_ADD_GAP  = 8'h60;

endpackage

`default_nettype wire

@@ hdl/sedc_store.sv @@
// ----------------------------------------------------------------------------
// sedc_store
// String byte buffer: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module sedc_store #(
  parameter int unsigned DEPTH = sedc_pkg::MAX_BYTES_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [AW-1:0]                waddr_i,
  input  wire logic [sedc_pkg::BYTE_W-1:0]  wdata_i,
  input  wire logic [AW-1:0]                raddr_i,
  output logic      [sedc_pkg::BYTE_W-1:0]  rdata_o
);

  logic [sedc_pkg::BYTE_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

@@ hdl/sedc_conv.sv @@
// ----------------------------------------------------------------------------
// sedc_conv
// Pair converter: SJIS to EUC, EUC to SJIS, or pass-through.
// ----------------------------------------------------------------------------
`default_nettype none

module sedc_conv (
  input  wire sedc_pkg::mode_e              mode_i,
  input  wire logic [sedc_pkg::BYTE_W-1:0]  lead_i,
  input  wire logic [sedc_pkg::BYTE_W-1:0]  trail_i,
  output logic      [sedc_pkg::BYTE_W-1:0]  lead_o,
  output logic      [sedc_pkg::BYTE_W-1:0]  trail_o
);

  logic [7:0] dbl;
  logic [7:0] half;
  logic       lead_hi;
  logic       lead_lo_euc;

  assign dbl         = {lead_i[6:0], 1'b0};
  assign half        = {1'b0, lead_i[7:1]};
  assign lead_hi     = (lead_i >= sedc_pkg::K_SJ_LEAD_HI);
  assign lead_lo_euc = (lead_i < sedc_pkg::K_EU_LEAD_SPL);

  always_comb begin
    lead_o  = lead_i;
    trail_o = trail_i;
    case (mode_i)
      sedc_pkg::MODE_TO_EUC: begin
        if (trail_i >= sedc_pkg::K_SJ_TR_SPL) begin
          lead_o  = dbl - (lead_hi ? sedc_pkg::K_SJ_SUB_HI : sedc_pkg::K_SJ_SUB_LO);
          trail_o = trail_i + sedc_pkg::K_SJ_ADD_TR;
        end else begin
          lead_o  = dbl - (lead_hi ? sedc_pkg::K_SJ_SUBO_HI : sedc_pkg::K_SJ_SUBO_LO);
          trail_o = trail_i + sedc_pkg::K_SJ_ADD_GAP
                    + {7'd0, (trail_i < sedc_pkg::K_SJ_TR_GAP)};
        end
      end
      sedc_pkg::MODE_TO_SJIS: begin
        if (lead_i[0]) begin
          lead_o  = half + (lead_lo_euc ? sedc_pkg::K_EU_ADDO_LO : sedc_pkg::K_EU_ADDO_HI);
          trail_o = trail_i - ((trail_i < sedc_pkg::K_EU_TR_SPL) ?
                               sedc_pkg::K_EU_SUB_LO : sedc_pkg::K_EU_SUB_HI);
        end else begin
          lead_o  = half + (lead_lo_euc ? sedc_pkg::K_EU_ADDE_LO : sedc_pkg::K_EU_ADDE_HI);
          trail_o = trail_i - sedc_pkg::K_EU_SUB_EVEN;
        end
      end
      default: begin
        lead_o  = lead_i;
        trail_o = trail_i;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hdl/sjis_euc_detect_convert_top.sv @@
// ----------------------------------------------------------------------------
// sjis_euc_detect_convert_top
// Loading takes one input beat per cycle. After the last beat the sequencer
// walks the buffer through its single read port: each byte is read, fetched
// and output, a pair adds a conversion step and a second output, and output
// steps wait while the stream stalls. Input is refused until the last byte is out.
// Reset: asynchronous, active low; clears control, verdict and config.
// ----------------------------------------------------------------------------
`default_nettype none

module sjis_euc_detect_convert_top #(
  parameter int unsigned MAX_BYTES = sedc_pkg::MAX_BYTES_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // APB
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [sedc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [sedc_pkg::APB_DW-1:0]    pwdata,
  output logic      [sedc_pkg::APB_DW-1:0]    prdata,
  output logic                                pready,
  // input stream
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [7:0]                     s_axis_tdata,   // [7:0] in_byte
  input  wire logic                           s_axis_tlast,   // is_last
  // output stream
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic      [7:0]                     m_axis_tdata,   // [7:0] out_byte
  output logic      [2:0]                     m_axis_tuser,   // [1:0] detected_code, [2] overflow
  output logic                                m_axis_tlast    // last_out
);

  localparam int unsigned CW = $clog2(MAX_BYTES + 1);
  localparam int unsigned AW = $clog2(MAX_BYTES);

  // configuration
  logic [1:0] sys_enc_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == sedc_pkg::REG_SYS_ENC);
  assign prdata = (paddr[2] == sedc_pkg::REG_SYS_ENC) ?
                  {{(sedc_pkg::APB_DW-2){1'b0}}, sys_enc_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sys_enc_q <= sedc_pkg::SYS_NONE;
    end else if (cfg_wr) begin
      sys_enc_q <= pwdata[1:0];
    end
  end

  // state
  sedc_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          trail_q, trail_d;
  logic [7:0]    held_q, held_d;
  logic [1:0]    verdict_q, verdict_d;
  logic          mixed_q, mixed_d;
  logic          ovf_q, ovf_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [7:0]    c1_q, c1_d;
  logic [7:0]    ob_a_q, ob_a_d;
  logic [7:0]    ob_b_q, ob_b_d;
  logic          pair_q, pair_d;

  logic          m_valid_q, m_valid_d;
  logic [7:0]    m_byte_q, m_byte_d;
  logic [1:0]    m_code_q, m_code_d;
  logic          m_ovf_q, m_ovf_d;
  logic          m_last_q, m_last_d;

  logic          in_acc;
  logic          st_we;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          is_euc, is_sjis;
  logic [1:0]    code;
  sedc_pkg::mode_e mode;
  logic [7:0]    cv_a, cv_b;
  logic          out_free;
  logic [CW-1:0] idx_p1, idx_p2;

  assign s_axis_tready = (state_q == sedc_pkg::S_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign st_we         = in_acc && (count_q < CW'(MAX_BYTES));
  assign idx_p1        = idx_q + CW'(1);
  assign idx_p2        = idx_q + CW'(2);

  sedc_store #(
    .DEPTH (MAX_BYTES),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // pair classes
  assign is_euc  = ((held_q >= 8'ha1 && held_q <= 8'hdf) ||
                    (held_q >= 8'hfd && held_q <= 8'hfe)) &&
                   (s_axis_tdata >= 8'ha1 && s_axis_tdata <= 8'hfe);
  assign is_sjis = ((held_q >= 8'h81 && held_q <= 8'h9f) &&
                    ((s_axis_tdata >= 8'h40 && s_axis_tdata <= 8'h7e) ||
                     (s_axis_tdata >= 8'h80 && s_axis_tdata <= 8'hfc))) ||
                   ((held_q >= 8'he0 && held_q <= 8'hfc) &&
                    (s_axis_tdata >= 8'h40 && s_axis_tdata <= 8'h7e));

  assign code = mixed_q ? sedc_pkg::CODE_UNKNOWN : verdict_q;

  always_comb begin
    mode = sedc_pkg::MODE_NONE;
    if (!ovf_q) begin
      if (code == sedc_pkg::CODE_SJIS && sys_enc_q == sedc_pkg::SYS_EUC) begin
        mode = sedc_pkg::MODE_TO_EUC;
      end else if (code == sedc_pkg::CODE_EUC && sys_enc_q == sedc_pkg::SYS_SJIS) begin
        mode = sedc_pkg::MODE_TO_SJIS;
      end
    end
  end

  sedc_conv u_conv (
    .mode_i  (mode),
    .lead_i  (c1_q),
    .trail_i (rd_data),
    .lead_o  (cv_a),
    .trail_o (cv_b)
  );

  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    trail_d   = trail_q;
    held_d    = held_q;
    verdict_d = verdict_q;
    mixed_d   = mixed_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    c1_d      = c1_q;
    ob_a_d    = ob_a_q;
    ob_b_d    = ob_b_q;
    pair_d    = pair_q;
    rd_addr   = idx_q[AW-1:0];
    m_valid_d = m_axis_tready ? 1'b0 : m_valid_q;
    m_byte_d  = m_byte_q;
    m_code_d  = m_code_q;
    m_ovf_d   = m_ovf_q;
    m_last_d  = m_last_q;

    case (state_q)
      sedc_pkg::S_LOAD: begin
        if (in_acc) begin
          if (st_we) begin
            count_d = count_q + CW'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (trail_q) begin
            trail_d = 1'b0;
            if ((is_euc || is_sjis) && !mixed_q) begin
              if (verdict_q == sedc_pkg::CODE_UNKNOWN) begin
                verdict_d = is_euc ? sedc_pkg::CODE_EUC : sedc_pkg::CODE_SJIS;
              end else if (verdict_q != (is_euc ? sedc_pkg::CODE_EUC : sedc_pkg::CODE_SJIS)) begin
                mixed_d = 1'b1;
              end
            end
          end else if (s_axis_tdata[7]) begin
            held_d  = s_axis_tdata;
            trail_d = 1'b1;
          end
          if (s_axis_tlast) begin
            idx_d   = '0;
            state_d = sedc_pkg::S_RD_A;
          end
        end
      end
      sedc_pkg::S_RD_A: begin
        rd_addr = idx_q[AW-1:0];
        state_d = sedc_pkg::S_GET_A;
      end
      sedc_pkg::S_GET_A: begin
        rd_addr = idx_p1[AW-1:0];
        c1_d    = rd_data;
        ob_a_d  = rd_data;
        if (rd_data[7] && (idx_p1 < count_q)) begin
          pair_d  = 1'b1;
          state_d = sedc_pkg::S_GET_B;
        end else begin
          pair_d  = 1'b0;
          state_d = sedc_pkg::S_OUT_A;
        end
      end
      sedc_pkg::S_GET_B: begin
        ob_a_d  = cv_a;
        ob_b_d  = cv_b;
        state_d = sedc_pkg::S_OUT_A;
      end
      sedc_pkg::S_OUT_A: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_byte_d  = ob_a_q;
          m_code_d  = code;
          m_ovf_d   = ovf_q;
          m_last_d  = (idx_p1 == count_q);
          if (pair_q) begin
            state_d = sedc_pkg::S_OUT_B;
          end else begin
            idx_d   = idx_p1;
            state_d = (idx_p1 == count_q) ? sedc_pkg::S_LOAD : sedc_pkg::S_RD_A;
          end
        end
      end
      sedc_pkg::S_OUT_B: begin
        if (out_free) begin
          m_valid_d = 1'b1;
          m_byte_d  = ob_b_q;
          m_code_d  = code;
          m_ovf_d   = ovf_q;
          m_last_d  = (idx_p2 == count_q);
          idx_d     = idx_p2;
          state_d   = (idx_p2 == count_q) ? sedc_pkg::S_LOAD : sedc_pkg::S_RD_A;
        end
      end
      default: begin
        state_d = sedc_pkg::S_LOAD;
      end
    endcase

    // drop string state once the final byte is handed to the output
    if (state_q != sedc_pkg::S_LOAD && state_d == sedc_pkg::S_LOAD) begin
      count_d   = '0;
      trail_d   = 1'b0;
      held_d    = '0;
      verdict_d = sedc_pkg::CODE_UNKNOWN;
      mixed_d   = 1'b0;
      ovf_d     = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= sedc_pkg::S_LOAD;
      count_q   <= '0;
      trail_q   <= 1'b0;
      held_q    <= '0;
      verdict_q <= sedc_pkg::CODE_UNKNOWN;
      mixed_q   <= 1'b0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      pair_q    <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      trail_q   <= trail_d;
      held_q    <= held_d;
      verdict_q <= verdict_d;
      mixed_q   <= mixed_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      pair_q    <= pair_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    c1_q     <= c1_d;
    ob_a_q   <= ob_a_d;
    ob_b_q   <= ob_b_d;
    m_byte_q <= m_byte_d;
    m_code_q <= m_code_d;
    m_ovf_q  <= m_ovf_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_byte_q;
  assign m_axis_tuser  = {m_ovf_q, m_code_q};
  assign m_axis_tlast  = m_last_q;

endmodule

`default_nettype wire

@@ bench/sedc_stream_checker.sv @@
// ----------------------------------------------------------------------------
// sedc_stream_checker
// Watches the APB port and both streams of the Shift_JIS / EUC-JP detector.
// Keeps its own copy of the string buffer, the pair classifier and the
// system encoding. On each last input beat it expands the stored string into
// the output beats it should produce. Each output beat is compared with the
// oldest of those beats, field by field. Register reads are compared with the
// shadow setting.
// ----------------------------------------------------------------------------
module sedc_stream_checker #(
  parameter int unsigned MAX_BYTES = sedc_pkg::MAX_BYTES_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [sedc_pkg::APB_AW-1:0] paddr,
  input  wire logic [sedc_pkg::APB_DW-1:0] pwdata,
  input  wire logic [sedc_pkg::APB_DW-1:0] prdata,
  input  wire logic                        pready,
  input  wire logic                        s_axis_tvalid,
  input  wire logic                        s_axis_tready,
  input  wire logic [7:0]                  s_axis_tdata,   // [7:0] in_byte
  input  wire logic                        s_axis_tlast,   // is_last
  input  wire logic                        m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  input  wire logic [7:0]                  m_axis_tdata,   // [7:0] out_byte
  input  wire logic [2:0]                  m_axis_tuser,   // [1:0] detected_code, [2] overflow
  input  wire logic                        m_axis_tlast,   // last_out
  output int unsigned                      fail_count_o,
  output int unsigned                      pending_o
);
  import sedc_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
    logic       ovf;
    logic       last;
  } str_beat_t;

  logic [7:0]  str_mem [MAX_BYTES];
  int unsigned str_len;
  logic        want_trail;
  logic [7:0]  lead_byte;
  logic [1:0]  str_code;
  logic        code_clash;
  logic        str_ovf;
  logic [1:0]  sys_enc;
  str_beat_t   string_out_q [$];
  int unsigned errs;

  function automatic logic [1:0] pair_class(logic [7:0] a, logic [7:0] b);
    logic euc;
    logic sjis;
    euc = ((a >= 8'ha1 && a <= 8'hdf) || (a >= 8'hfd && a <= 8'hfe)) &&
          (b >= 8'ha1 && b <= 8'hfe);
    sjis = ((a >= 8'h81 && a <= 8'h9f) &&
            ((b >= 8'h40 && b <= 8'h7e) || (b >= 8'h80 && b <= 8'hfc))) ||
           ((a >= 8'he0 && a <= 8'hfc) && (b >= 8'h40 && b <= 8'h7e));
    if (euc) return CODE_EUC;
    if (sjis) return CODE_SJIS;
    return CODE_UNKNOWN;
  endfunction

  function automatic logic [15:0] sjis_pair_to_euc(logic [7:0] a, logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    if (b >= 8'h9f) begin
      hi = {a[6:0], 1'b0} - ((a >= 8'he0) ? 8'he0 : 8'h60);
      lo = b + 8'h02;
    end else begin
      hi = {a[6:0], 1'b0} - ((a >= 8'he0) ? 8'he1 : 8'h61);
      lo = b + ((b < 8'h7f) ? 8'h61 : 8'h60);
    end
    return {hi, lo};
  endfunction

  function automatic logic [15:0] euc_pair_to_sjis(logic [7:0] a, logic [7:0] b);
    logic [7:0] hi;
    logic [7:0] lo;
    if (a[0]) begin
      hi = {1'b0, a[7:1]} + ((a < 8'hdf) ? 8'h31 : 8'h71);
      lo = b - ((b < 8'he0) ? 8'h61 : 8'h60);
    end else begin
      hi = {1'b0, a[7:1]} + ((a < 8'hdf) ? 8'h30 : 8'h70);
      lo = b - 8'h02;
    end
    return {hi, lo};
  endfunction

  function void clear_string();
    str_len    = 0;
    want_trail = 1'b0;
    lead_byte  = 8'h00;
    str_code   = CODE_UNKNOWN;
    code_clash = 1'b0;
    str_ovf    = 1'b0;
  endfunction

  function void push_out(logic [7:0] c, logic [1:0] code, int unsigned idx);
    string_out_q.push_back(str_beat_t'{data: c, code: code, ovf: str_ovf,
                                       last: (idx + 1 == str_len)});
  endfunction

  function void emit_string();
    logic [1:0]  code;
    mode_e       mode;
    int unsigned i;
    logic [7:0]  c1;
    logic [7:0]  c2;
    code = code_clash ? CODE_UNKNOWN : str_code;
    mode = MODE_NONE;
    if (!str_ovf) begin
      if (code == CODE_SJIS && sys_enc == SYS_EUC) mode = MODE_TO_EUC;
      else if (code == CODE_EUC && sys_enc == SYS_SJIS) mode = MODE_TO_SJIS;
    end
    i = 0;
    while (i < str_len) begin
      c1 = str_mem[i];
      if (c1[7] && i + 1 < str_len) begin
        c2 = str_mem[i + 1];
        if (mode == MODE_TO_EUC) {c1, c2} = sjis_pair_to_euc(c1, c2);
        else if (mode == MODE_TO_SJIS) {c1, c2} = euc_pair_to_sjis(c1, c2);
        push_out(c1, code, i);
        push_out(c2, code, i + 1);
        i += 2;
      end else begin
        push_out(c1, code, i);
        i += 1;
      end
    end
    clear_string();
  endfunction

  function void load_byte(logic [7:0] b, logic last);
    logic [1:0] cls;
    if (str_len < MAX_BYTES) begin
      str_mem[str_len] = b;
      str_len++;
    end else begin
      str_ovf = 1'b1;
    end
    if (want_trail) begin
      cls = pair_class(lead_byte, b);
      if (cls != CODE_UNKNOWN && !code_clash) begin
        if (str_code == CODE_UNKNOWN) str_code = cls;
        else if (str_code != cls) code_clash = 1'b1;
      end
      want_trail = 1'b0;
    end else if (b[7]) begin
      lead_byte  = b;
      want_trail = 1'b1;
    end
    if (last) emit_string();
  endfunction

  function void check_beat();
    str_beat_t exp_b;
    if (string_out_q.size() == 0) begin
      $error("out_byte: no beat expected, actual %02h", m_axis_tdata);
      errs++;
      return;
    end
    exp_b = string_out_q.pop_front();
    if (m_axis_tdata !== exp_b.data) begin
      $error("out_byte: expected %02h, actual %02h", exp_b.data, m_axis_tdata);
      errs++;
    end
    if (m_axis_tuser[1:0] !== exp_b.code) begin
      $error("detected_code: expected %0d, actual %0d", exp_b.code, m_axis_tuser[1:0]);
      errs++;
    end
    if (m_axis_tuser[2] !== exp_b.ovf) begin
      $error("overflow: expected %0d, actual %0d", exp_b.ovf, m_axis_tuser[2]);
      errs++;
    end
    if (m_axis_tlast !== exp_b.last) begin
      $error("last_out: expected %0d, actual %0d", exp_b.last, m_axis_tlast);
      errs++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_string();
      sys_enc = SYS_NONE;
      string_out_q.delete();
      errs = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) check_beat();
      if (psel && penable && pready && paddr[2] == REG_SYS_ENC) begin
        if (pwrite) begin
          sys_enc = pwdata[1:0];
        end else if (prdata !== {{(APB_DW-2){1'b0}}, sys_enc}) begin
          $error("system_encoding: expected %0d, actual %0d", sys_enc, prdata);
          errs++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) load_byte(s_axis_tdata, s_axis_tlast);
      fail_count_o <= errs;
      pending_o    <= string_out_q.size();
    end
  end

endmodule

@@ bench/tb_sjis_euc_detect_convert_top.sv @@
// ----------------------------------------------------------------------------
// tb_sjis_euc_detect_convert_top
// Drives strings into the Shift_JIS / EUC-JP detector under each system
// encoding: a directed set of pair extremes, mixed and unclassified pairs and
// a lone lead byte, then random EUC, SJIS, mixed and noise strings, one full
// and one overflowing. The input side sends in bursts, the output side
// stalls on its own pattern. The checker instance reports the failure count.
// ----------------------------------------------------------------------------
module tb_sjis_euc_detect_convert_top;
  import sedc_pkg::*;

  localparam int unsigned CLK_PERIOD     = 12;
  localparam int unsigned TIMEOUT_CYCLES = 200000;
  localparam int unsigned RANDOM_ITEMS   = 285;

  typedef enum {STR_EUC, STR_SJIS, STR_MIXED, STR_NOISE} str_style_e;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_e;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [APB_DW-1:0] pwdata        = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata  = 8'h00;
  logic              s_axis_tlast  = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [7:0]        m_axis_tdata;
  logic [2:0]        m_axis_tuser;
  logic              m_axis_tlast;
  int unsigned       fail_count;
  int unsigned       pending;

  logic [7:0]  tx_bytes [$];
  int unsigned burst_left = 0;
  logic        calm       = 1'b0;
  int unsigned items_sent = 0;
  rx_mode_e    rx_mode    = RX_OPEN;
  int unsigned rx_span    = 0;
  int unsigned rx_hold    = 0;

  sjis_euc_detect_convert_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  sedc_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (rx_span == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_span = $urandom_range(20, 80);
    end
    rx_span--;
    case (rx_mode)
      RX_OPEN:   m_axis_tready <= 1'b1;
      RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: begin
        if (rx_hold == 0) begin
          m_axis_tready <= ~m_axis_tready;
          rx_hold = $urandom_range(1, 12);
        end else begin
          rx_hold--;
        end
      end
    endcase
  end

  task automatic apb_access(input logic wr, input logic [1:0] val);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = {REG_SYS_ENC, 2'b00};
    pwdata  = {{(APB_DW-2){1'b0}}, val};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic set_encoding(input logic [1:0] val);
    apb_access(1'b1, val);
    apb_access(1'b0, 2'd0);
  endtask

  task automatic send_beat(input logic [7:0] b, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!calm) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk_i);
      end
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    s_axis_tlast  = last;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_str();
    for (int i = 0; i < tx_bytes.size(); i++) send_beat(tx_bytes[i], i == tx_bytes.size() - 1);
  endtask

  // hold off until every emitted byte is back, then let the sequencer settle
  task automatic wait_drain();
    s_axis_tvalid = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic build_str(input str_style_e style, input int unsigned len);
    int unsigned r;
    tx_bytes.delete();
    while (tx_bytes.size() < len) begin
      r = $urandom_range(0, 9);
      if (r < 3) begin
        tx_bytes.push_back(8'($urandom_range(1, 8'h7f)));
      end else if (r == 9 || style == STR_NOISE) begin
        tx_bytes.push_back(8'($urandom_range(1, 8'hff)));
      end else if (style == STR_EUC || (style == STR_MIXED && $urandom_range(0, 1))) begin
        if ($urandom_range(0, 7) == 0) tx_bytes.push_back(8'($urandom_range(8'hfd, 8'hfe)));
        else tx_bytes.push_back(8'($urandom_range(8'ha1, 8'hdf)));
        tx_bytes.push_back(8'($urandom_range(8'ha1, 8'hfe)));
      end else if ($urandom_range(0, 1)) begin
        tx_bytes.push_back(8'($urandom_range(8'h81, 8'h9f)));
        if ($urandom_range(0, 1)) tx_bytes.push_back(8'($urandom_range(8'h40, 8'h7e)));
        else tx_bytes.push_back(8'($urandom_range(8'h80, 8'hfc)));
      end else begin
        tx_bytes.push_back(8'($urandom_range(8'he0, 8'hfc)));
        tx_bytes.push_back(8'($urandom_range(8'h40, 8'h7e)));
      end
    end
    while (tx_bytes.size() > len) void'(tx_bytes.pop_back());
  endtask

  initial begin
    int unsigned phase;
    int unsigned str_idx;
    int unsigned len;
    logic [1:0]  enc;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    repeat (2) @(negedge clk_i);

    calm = 1'b1;
    set_encoding(SYS_EUC);
    tx_bytes = '{8'h81, 8'h40, 8'h9f, 8'hfc, 8'hfc, 8'h7e, 8'h41};
    send_str();
    tx_bytes = '{8'h41, 8'h88};
    send_str();
    tx_bytes = '{8'h00, 8'h01};
    send_str();
    wait_drain();
    calm = 1'b0;
    set_encoding(SYS_SJIS);
    tx_bytes = '{8'ha1, 8'ha1, 8'hfe, 8'hfe, 8'hdf, 8'hfd};
    send_str();
    tx_bytes = '{8'ha4, 8'ha2, 8'h82, 8'ha0};
    send_str();
    tx_bytes = '{8'hb0, 8'hb1, 8'h80, 8'h31, 8'hff};
    send_str();
    wait_drain();

    items_sent = 0;
    phase      = 0;
    str_idx    = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case (phase)
        0:       enc = SYS_NONE;
        1:       enc = SYS_EUC;
        2:       enc = SYS_SJIS;
        default: enc = 2'($urandom_range(0, 2));
      endcase
      set_encoding(enc);
      calm = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(2, 5)) begin
        if (str_idx == 4) len = MAX_BYTES_DEF;
        else if (str_idx == 11) len = MAX_BYTES_DEF + $urandom_range(1, 4);
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(11, 30);
        else len = $urandom_range(1, 10);
        build_str(str_style_e'($urandom_range(0, 3)), len);
        send_str();
        str_idx++;
      end
      wait_drain();
      phase++;
    end

    repeat (40) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Test completed with failures");
    $finish;
  end

endmodule

@@ sjis_euc_detect_convert_top.f @@
hdl/sedc_pkg.sv
hdl/sedc_store.sv
hdl/sedc_conv.sv
hdl/sjis_euc_detect_convert_top.sv
bench/sedc_stream_checker.sv
bench/tb_sjis_euc_detect_convert_top.sv
